@@ src/cvvl_pkg.sv @@
// cvvl_pkg: beat types, widths and constants for the circular voltage vector limiter
// no dependencies
package cvvl_pkg;

    localparam int unsigned RADIUS_GAIN  = 5793;
    localparam int unsigned RADIUS_SHIFT = 13 + 5;
    localparam int unsigned SCALE_SHIFT  = 14;
    localparam int unsigned DUTY_W       = 6;
    localparam logic [DUTY_W-1:0] DUTY_RESET = 6'd32;
    // radius < 2^15*5793*63 >> 18 -> fits 20 bits
    localparam int unsigned RAD_W = 20;
    localparam int unsigned R2_W  = 31;   // vd^2+vq^2 <= 2^31
    localparam int unsigned MAG_W = 16;   // floor_sqrt of r2 fits 16 bits
    localparam int unsigned NUM_W = RAD_W + SCALE_SHIFT;  // dividend width
    localparam int unsigned SQ_STEPS  = 16;  // one root bit per cell
    localparam int unsigned DIV_STEPS = 15;  // scale <= 16384 -> 15 quotient bits
    localparam int unsigned SCL_W = 15;

    typedef struct packed {
        logic signed [15:0] vd_in;
        logic signed [15:0] vq_in;
        logic [14:0]        vdc_bus;
    } in_beat_t;

    typedef struct packed {
        logic signed [15:0] vd_out;
        logic signed [15:0] vq_out;
        logic signed [15:0] vd_excess;
        logic signed [15:0] vq_excess;
        logic               was_limited;
    } out_beat_t;

    // work carried from cell to cell
    typedef struct packed {
        logic               vld;
        logic signed [15:0] vd;
        logic signed [15:0] vq;
        logic               lim;
        logic [RAD_W-1:0]   radius;
        logic [R2_W:0]      rem;    // sqrt remainder
        logic [MAG_W-1:0]   root;   // sqrt partial root
        logic [R2_W:0]      x;      // unconsumed radicand bits
        logic [NUM_W-1:0]   num;    // divide: dividend bits shifted in
        logic [MAG_W:0]     drem;   // divide partial remainder
        logic [SCL_W-1:0]   quo;
    } cell_data_t;

endpackage

@@ src/cvvl_sqrt_cell.sv @@
// cvvl_sqrt_cell: one restoring square-root step (one root bit) per cell
// depends on cvvl_pkg
module cvvl_sqrt_cell
    import cvvl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  cell_data_t d,
    output cell_data_t q
);
    cell_data_t                    q_next;
    logic                          vld_reg;
    logic [$bits(cell_data_t)-2:0] body_reg;
    logic [R2_W:0]    trial_rem;
    logic [R2_W:0]    trial;

    always_comb
    begin
        q_next    = d;
        trial_rem = {d.rem[R2_W-2:0], d.x[R2_W:R2_W-1]};
        trial     = {{(R2_W-MAG_W-1){1'b0}}, d.root, 2'b01};
        q_next.x  = {d.x[R2_W-2:0], 2'b00};
        if (trial_rem >= trial)
        begin
            q_next.rem  = trial_rem - trial;
            q_next.root = {d.root[MAG_W-2:0], 1'b1};
        end
        else
        begin
            q_next.rem  = trial_rem;
            q_next.root = {d.root[MAG_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= q_next.vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            body_reg <= q_next[$bits(cell_data_t)-2:0];
    end

    assign q = {vld_reg, body_reg};
endmodule

@@ src/cvvl_div_cell.sv @@
// cvvl_div_cell: one restoring division step (one quotient bit) per cell
// depends on cvvl_pkg; divisor is the root from the square-root cells
module cvvl_div_cell
    import cvvl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  cell_data_t d,
    output cell_data_t q
);
    cell_data_t                    q_next;
    logic                          vld_reg;
    logic [$bits(cell_data_t)-2:0] body_reg;
    logic [MAG_W:0] trial;
    logic [MAG_W:0] dvs;

    always_comb
    begin
        q_next  = d;
        trial   = {d.drem[MAG_W-1:0], d.num[NUM_W-1]};
        dvs     = {1'b0, d.root};
        q_next.num = {d.num[NUM_W-2:0], 1'b0};
        if (trial >= dvs)
        begin
            q_next.drem = trial - dvs;
            q_next.quo  = {d.quo[SCL_W-2:0], 1'b1};
        end
        else
        begin
            q_next.drem = trial;
            q_next.quo  = {d.quo[SCL_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= q_next.vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            body_reg <= q_next[$bits(cell_data_t)-2:0];
    end

    assign q = {vld_reg, body_reg};
endmodule

@@ src/circular_voltage_vector_limiter.sv @@
// circular_voltage_vector_limiter: top level, front end, chain of sqrt and divide cells,
// scaling stage and output register; depends on cvvl_pkg, cvvl_sqrt_cell, cvvl_div_cell
// throughput: one beat per cycle; the whole chain advances together and stalls
// only when the output register is full and not taken
// reset: rst_n clears all valid bits; duty_reg returns to 32 (full)
module circular_voltage_vector_limiter
    import cvvl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_beat_t          in_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [DUTY_W-1:0] cfg_data,
    output logic              out_valid,
    input  logic              out_ready,
    output out_beat_t         out_data
);
    logic [DUTY_W-1:0] duty_reg;
    logic              adv;

    // output register empty or being taken -> whole pipe moves
    assign adv       = !out_valid || out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            duty_reg <= DUTY_RESET;
        else if (cfg_valid)
            duty_reg <= cfg_data;
    end

    // stage a: products of the input (one multiplier each)
    logic               a_vld_reg;
    logic signed [15:0] a_vd_reg, a_vq_reg;
    logic [29:0]        a_sqd_reg, a_sqq_reg;
    logic [27:0]        a_vg_reg;     // vdc*5793

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else if (adv)
            a_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_vd_reg  <= in_data.vd_in;
            a_vq_reg  <= in_data.vq_in;
            a_sqd_reg <= 30'(in_data.vd_in * in_data.vd_in);
            a_sqq_reg <= 30'(in_data.vq_in * in_data.vq_in);
            a_vg_reg  <= 28'({13'd0, in_data.vdc_bus} * 28'(RADIUS_GAIN));
        end
    end

    // squares of 16-bit signed values: -32768^2 = 2^30 needs 31 bits
    logic [30:0] sqd_full, sqq_full;
    assign sqd_full = (a_vd_reg == -16'sd32768) ? 31'h4000_0000 : {1'b0, a_sqd_reg};
    assign sqq_full = (a_vq_reg == -16'sd32768) ? 31'h4000_0000 : {1'b0, a_sqq_reg};

    // stage b: radius, r2
    logic               b_vld_reg;
    logic signed [15:0] b_vd_reg, b_vq_reg;
    logic [RAD_W-1:0]   b_rad_reg;
    logic [R2_W:0]      b_r2_reg;
    logic [33:0]        rad_prod;

    assign rad_prod = a_vg_reg * duty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_vld_reg <= 1'b0;
        else if (adv)
            b_vld_reg <= a_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_vd_reg  <= a_vd_reg;
            b_vq_reg  <= a_vq_reg;
            b_rad_reg <= RAD_W'(rad_prod >> RADIUS_SHIFT);
            b_r2_reg  <= {1'b0, sqd_full} + {1'b0, sqq_full};
        end
    end

    // stage c: compare r2 with radius^2, load the cell chain
    logic [39:0] lim2;
    cell_data_t  chain [SQ_STEPS+1];

    assign lim2 = b_rad_reg * b_rad_reg;

    always_comb
    begin
        chain[0]        = '0;
        chain[0].vld    = b_vld_reg;
        chain[0].vd     = b_vd_reg;
        chain[0].vq     = b_vq_reg;
        chain[0].lim    = {8'd0, b_r2_reg} > lim2;
        chain[0].radius = b_rad_reg;
        chain[0].x      = b_r2_reg;
    end

    genvar gi;
    generate
        for (gi = 0; gi < SQ_STEPS; gi++)
        begin : g_sq
            cvvl_sqrt_cell u_sq (
                .clk  (clk),
                .rst_n(rst_n),
                .en   (adv),
                .d    (chain[gi]),
                .q    (chain[gi+1])
            );
        end
    endgenerate

    // after the sqrt cells: load the dividend radius<<14
    // quotient fits 15 bits, so top 19 dividend bits are preloaded as remainder
    cell_data_t div_in;
    always_comb
    begin
        div_in      = chain[SQ_STEPS];
        div_in.num  = NUM_W'({chain[SQ_STEPS].radius, {SCALE_SHIFT{1'b0}}}) << (NUM_W-DIV_STEPS);
        div_in.drem = (MAG_W+1)'(chain[SQ_STEPS].radius >> (DIV_STEPS-SCALE_SHIFT));
        div_in.quo  = '0;
        // root is never zero when limiting; guard the idle case
        if (chain[SQ_STEPS].root == '0)
            div_in.root = MAG_W'(1);
    end

    cell_data_t dchain [DIV_STEPS+1];
    assign dchain[0] = div_in;

    generate
        for (gi = 0; gi < DIV_STEPS; gi++)
        begin : g_dv
            cvvl_div_cell u_dv (
                .clk  (clk),
                .rst_n(rst_n),
                .en   (adv),
                .d    (dchain[gi]),
                .q    (dchain[gi+1])
            );
        end
    endgenerate

    // scaling stage: v*scale, floor >> 14
    cell_data_t          e_d;
    logic                s_vld_reg, s_lim_reg;
    logic signed [15:0]  s_vd_reg, s_vq_reg;
    logic signed [31:0]  s_pd_reg, s_pq_reg;

    assign e_d = dchain[DIV_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_vld_reg <= 1'b0;
        else if (adv)
            s_vld_reg <= e_d.vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_lim_reg <= e_d.lim;
            s_vd_reg  <= e_d.vd;
            s_vq_reg  <= e_d.vq;
            s_pd_reg  <= e_d.vd * $signed({1'b0, e_d.quo});
            s_pq_reg  <= e_d.vq * $signed({1'b0, e_d.quo});
        end
    end

    // arithmetic shift is floor, matching the model's rounding toward minus infinity
    logic signed [15:0] od, oq;
    assign od = s_lim_reg ? 16'(s_pd_reg >>> SCALE_SHIFT) : s_vd_reg;
    assign oq = s_lim_reg ? 16'(s_pq_reg >>> SCALE_SHIFT) : s_vq_reg;

    // output register
    out_beat_t out_reg;
    logic      out_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= s_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg.vd_out      <= od;
            out_reg.vq_out      <= oq;
            out_reg.vd_excess   <= s_vd_reg - od;
            out_reg.vq_excess   <= s_vq_reg - oq;
            out_reg.was_limited <= s_lim_reg;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;
endmodule

@@ verif/cvvl_checker.sv @@
`timescale 1ns / 1ps
// cvvl_checker: watches the input, config and output channels, predicts each limited vector
// and compares it with what the limiter returns; depends on cvvl_pkg
module cvvl_checker
    import cvvl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  in_beat_t          in_data,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [DUTY_W-1:0] cfg_data,
    input  logic              out_valid,
    input  logic              out_ready,
    input  out_beat_t         out_data,
    output int                fail_count,
    output int                pending
);

    logic [DUTY_W-1:0] duty_q5;
    out_beat_t         limited_q[$];

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] b;
        root = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= root + b)
            begin
                x = x - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root;
    endfunction

    // floor of v*scale / 2^14, rounding toward minus infinity
    function automatic longint shrink_axis(input longint v, input longint scale);
        longint p;
        p = v * scale;
        if (p >= 0)
            return p >>> SCALE_SHIFT;
        return -((-p + (64'd1 << SCALE_SHIFT) - 1) >>> SCALE_SHIFT);
    endfunction

    function automatic out_beat_t limit_vector(input in_beat_t b, input logic [DUTY_W-1:0] duty);
        longint    vd;
        longint    vq;
        longint    od;
        longint    oq;
        logic [63:0] radius;
        logic [63:0] r2;
        logic [63:0] scale;
        out_beat_t r;
        vd = longint'(b.vd_in);
        vq = longint'(b.vq_in);
        radius = (64'(b.vdc_bus) * RADIUS_GAIN * 64'(duty)) >> RADIUS_SHIFT;
        r2 = 64'(vd * vd) + 64'(vq * vq);
        od = vd;
        oq = vq;
        r.was_limited = 1'b0;
        if (r2 > radius * radius)
        begin
            scale = (radius << SCALE_SHIFT) / isqrt64(r2);
            od = shrink_axis(vd, longint'(scale));
            oq = shrink_axis(vq, longint'(scale));
            r.was_limited = 1'b1;
        end
        r.vd_out    = od[15:0];
        r.vq_out    = oq[15:0];
        r.vd_excess = 16'(vd - od);
        r.vq_excess = 16'(vq - oq);
        return r;
    endfunction

    assign pending = limited_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t want;
        if (!rst_n)
        begin
            duty_q5 <= DUTY_RESET;
            fail_count <= 0;
            limited_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                duty_q5 <= cfg_data;
            if (out_valid && out_ready)
            begin
                if (limited_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected output beat %h", out_data);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = limited_q.pop_front();
                    if (want !== out_data)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: exp vd=%0d vq=%0d ed=%0d eq=%0d lim=%0b, got vd=%0d vq=%0d ed=%0d eq=%0d lim=%0b",
                                want.vd_out, want.vq_out, want.vd_excess, want.vq_excess,
                                want.was_limited, out_data.vd_out, out_data.vq_out,
                                out_data.vd_excess, out_data.vq_excess, out_data.was_limited);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                limited_q.push_back(limit_vector(in_data, duty_q5));
        end
    end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for the circular voltage vector limiter
// depends on cvvl_pkg, circular_voltage_vector_limiter and cvvl_checker
module tb_top;
    import cvvl_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    in_beat_t          in_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [DUTY_W-1:0] cfg_data;
    logic              out_valid;
    logic              out_ready = 1'b0;
    out_beat_t         out_data;
    int                fail_count;
    int                pending;
    int                cycle_count = 0;
    int                send_idle_pct;
    int                recv_idle_pct;

    circular_voltage_vector_limiter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    cvvl_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #6 clk = ~clk;
    end

    // receiver stalls at random, rate set per phase
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // watchdog: budget sized for 2000 beats at worst-case stall plus drain, taken several times
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 200000)
        begin
            $display("** circular_voltage_vector_limiter: FAILED **");
            $finish;
        end
    end

    // one vector beat, with a random gap before it at the sender's idle rate
    // valid stays up after the beat so the next one can follow with no gap
    task automatic send_vector(input logic [15:0] vd, input logic [15:0] vq,
                               input logic [14:0] vdc);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{vd_in: vd, vq_in: vq, vdc_bus: vdc};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // drop valid and wait until every accepted beat has come back
    task automatic drain_pipe();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // duty writes only with the pipeline empty
    task automatic write_duty(input logic [DUTY_W-1:0] duty);
        drain_pipe();
        repeat (40) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= duty;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly vectors near the circle so both branches get hit
    task automatic random_vectors(input int count);
        logic [15:0] vd;
        logic [15:0] vq;
        logic [14:0] vdc;
        for (int i = 0; i < count; i++)
        begin
            vdc = $urandom_range(3) == 0 ? 15'($urandom) : 15'($urandom_range(16000, 32767));
            case ($urandom_range(3))
                0: begin vd = 16'($urandom); vq = 16'($urandom); end
                1: begin vd = 16'($urandom_range(8000)); vq = 16'($urandom_range(8000)); end
                2: begin vd = -16'($urandom_range(20000)); vq = 16'($urandom_range(20000)); end
                default: begin vd = 16'($urandom_range(3) - 2); vq = 16'($urandom); end
            endcase
            send_vector(vd, vq, vdc);
        end
    endtask

    initial
    begin
        logic [DUTY_W-1:0] duty_set[6];
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        send_idle_pct = 25;
        recv_idle_pct = 48;
        duty_set = '{6'd0, 6'd63, 6'd1, 6'd16, 6'd32, 6'd45};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes at reset duty, on/inside/outside circle
        send_vector(16'h0000, 16'h0000, 15'h7fff);
        send_vector(16'h7fff, 16'h7fff, 15'h7fff);
        send_vector(16'h8000, 16'h8000, 15'h7fff);
        send_vector(16'h8000, 16'h7fff, 15'h0000);
        send_vector(16'h0000, 16'h0000, 15'h0000);
        send_vector(16'h0001, 16'hffff, 15'h0000);
        send_vector(16'd100, 16'd0, 15'd500);
        send_vector(16'd20000, 16'h0000, 15'h7fff);
        send_vector(16'h0000, -16'd30000, 15'd100);
        send_vector(16'h5555, 16'haaaa, 15'h2aaa);
        send_vector(16'haaaa, 16'h5555, 15'h5555);
        send_vector(16'd2896, 16'd0, 15'd4096);
        send_vector(16'd2897, 16'd0, 15'd4096);
        // zero duty: zero radius, above-full duty: radius past 15 bits
        write_duty(6'd0);
        send_vector(16'd5, -16'd3, 15'h7fff);
        send_vector(16'h0000, 16'h0000, 15'h7fff);
        write_duty(6'd63);
        send_vector(16'h8000, 16'h8000, 15'h7fff);
        send_vector(16'h7fff, 16'h8000, 15'h7fff);
        send_vector(16'h8000, 16'h0000, 15'd100);

        for (int phase = 0; phase < 6; phase++)
        begin
            write_duty(duty_set[phase]);
            if (phase == 2)
            begin
                send_idle_pct = 48;
                recv_idle_pct = 25;
            end
            if (phase == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_vectors(150);
            // hold off until the pipeline has drained completely
            drain_pipe();
            random_vectors(150);
        end

        drain_pipe();
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("** circular_voltage_vector_limiter: PASSED **");
        else
            $display("** circular_voltage_vector_limiter: FAILED **");
        $finish;
    end

endmodule
